FILE: sv/tpmd_pkg.sv
// Shared types, field positions and constants of the tabular policy motor drive.
package tpmd_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int ADDR_W       = 17;
    localparam int ACTION_W     = 2;
    localparam int MAG_W        = 11;
    localparam int DRIVE_W      = 13;
    localparam int DECAY_W      = 14;
    localparam int GATE_ANGLE_W = 5;
    localparam int GATE_RATE_W  = 6;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 6;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 16;
    localparam int STEP_W       = 3;

    localparam int ADDR_LSB   = 0;
    localparam int ACTION_LSB = 17;
    localparam int ANGLE_LSB  = 19;
    localparam int RATE_LSB   = 43;
    localparam int WHEEL_LSB  = 67;

    localparam int ANGLE_HALF_SPAN = 23040;
    localparam int RATE_HALF_SPAN  = 29335;
    localparam int WHEEL_HALF_SPAN = 440032;

    localparam logic signed [DRIVE_W-1:0] DRIVE_KICK   = 13'sd2180;
    localparam logic signed [14:0]        DECAY_OFFSET = 15'sd1200;
    localparam logic [DECAY_W-1:0]        RECIP_FIVE   = 14'd13108;
    localparam int                        RECIP_SHIFT  = 16;
    localparam logic [MAG_W-1:0]          MAG_MAX      = 11'd1984;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic signed [ACTION_W-1:0] ACT_INVALID = 2'sb10;
    localparam logic signed [ACTION_W-1:0] ACT_NEG     = 2'sb11;
    localparam logic signed [ACTION_W-1:0] ACT_ZERO    = 2'sb00;
    localparam logic signed [ACTION_W-1:0] ACT_POS     = 2'sb01;

    localparam logic [CFG_INDEX_W-1:0] REG_GATE_ANGLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_RATE  = 1'b1;

    typedef struct packed {
        logic              write;
        logic              load;
        logic              step;
        logic [STEP_W-1:0] step_bit;
        logic              addr1;
        logic              addr2;
        logic              read;
        logic              update;
        logic              decay1;
        logic              decay2;
    } tpmd_cmd_t;

endpackage

FILE: sv/tabular_policy_motor_drive_top.sv
// Top level of the tabular policy motor drive.
// Requests arrive on the s_ stream. s_tuser selects the kind: 0 writes one
// policy entry into the table, 1 is a control tick that produces one result.
// A table write produces nothing on the m_ stream.
// A control tick quantizes its three measurements by a bitwise grid search,
// one bit per cycle over the widest grid index, then forms the table address,
// reads the table, updates action and drive, and decays the drive.
// A tick does not overlap the next request: s_tready stays low until the
// tick has finished and its result is shown.
// The result sits in an output register; while the receiver stalls the
// block runs the tick up to its last decay step, then waits for the slot.
// The cfg channel writes the two gate registers and is always ready.
// Reset clears action, drive, gate registers and handshake state at once.
// The policy table has no reset; every entry that ticks reach must be written.
module tabular_policy_motor_drive_top #(
    parameter int ANGLE_POINTS = 20,
    parameter int RATE_POINTS  = 50,
    parameter int WHEEL_POINTS = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_address, entry_action, body_angle, body_rate, wheel_rate, zero pad
    input  logic [tpmd_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chosen_action, reverse_direction, drive_magnitude, zero pad
    output logic [tpmd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tpmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(ANGLE_POINTS);
    localparam int RW = $clog2(RATE_POINTS);
    localparam int WW = $clog2(WHEEL_POINTS);
    localparam int SW = (WW > RW) ? ((WW > AW) ? WW : AW) : ((RW > AW) ? RW : AW);

    tpmd_pkg::tpmd_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tpmd_ctrl #(
        .SEARCH_STEPS (SW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tpmd_datapath #(
        .ANGLE_POINTS (ANGLE_POINTS),
        .RATE_POINTS  (RATE_POINTS),
        .WHEEL_POINTS (WHEEL_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: sv/tpmd_snap.sv
// Grid quantizer: bitwise search for the nearest point of a uniform grid.
module tpmd_snap #(
    parameter int POINTS = 20,
    parameter int HALF   = 23040
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  step,
    input  logic [tpmd_pkg::STEP_W-1:0]           step_bit,
    input  logic signed [tpmd_pkg::SAMPLE_W-1:0]  sample,
    output logic [$clog2(POINTS)-1:0]             index
);

    localparam int IW = $clog2(POINTS);
    localparam int PW = IW + 28;
    localparam logic signed [PW-1:0] HALF_W = PW'(HALF);
    localparam logic signed [PW-1:0] SPAN_W = PW'(POINTS - 1);
    localparam logic [IW-1:0]        LAST   = IW'(POINTS - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_next;
    logic [IW-1:0]        cand;
    logic signed [IW+1:0] odd;
    logic signed [PW-1:0] thr;

    always_comb
    begin
        prod_next = (PW'(sample) + HALF_W) * SPAN_W;
        cand      = idx_reg | (IW'(1) << step_bit);
        odd       = $signed({1'b0, cand, 1'b0}) - 2'sd1;
        thr       = PW'(odd) * HALF_W;
        idx_next  = idx_reg;
        if (load)
        begin
            idx_next = '0;
        end
        else if (step && (cand <= LAST) && (thr < prod_reg))
        begin
            idx_next = cand;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
        idx_reg <= idx_next;
    end

    assign index = idx_reg;

endmodule

FILE: sv/tpmd_ctrl.sv
// Sequencing state machine of the tabular policy motor drive.
module tpmd_ctrl #(
    parameter int SEARCH_STEPS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_kind,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tpmd_pkg::tpmd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADDR1,
        ST_ADDR2,
        ST_READ,
        ST_UPDATE,
        ST_DECAY1,
        ST_DECAY2
    } state_t;

    localparam logic [tpmd_pkg::STEP_W-1:0] LAST_STEP = tpmd_pkg::STEP_W'(SEARCH_STEPS - 1);

    state_t                        state_reg;
    state_t                        state_next;
    logic [tpmd_pkg::STEP_W-1:0]   step_reg;
    logic [tpmd_pkg::STEP_W-1:0]   step_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          slot_free;

    always_comb
    begin
        cmd            = '0;
        cmd.step_bit   = step_reg;
        state_next     = state_reg;
        step_next      = step_reg;
        slot_free      = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_kind == tpmd_pkg::KIND_TICK)
                    begin
                        cmd.load   = 1'b1;
                        step_next  = LAST_STEP;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_ADDR1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ADDR1:
            begin
                cmd.addr1  = 1'b1;
                state_next = ST_ADDR2;
            end
            ST_ADDR2:
            begin
                cmd.addr2  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DECAY1;
            end
            ST_DECAY1:
            begin
                cmd.decay1 = 1'b1;
                state_next = ST_DECAY2;
            end
            ST_DECAY2:
            begin
                if (slot_free)
                begin
                    cmd.decay2     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write, cmd.load, cmd.step, cmd.addr1, cmd.addr2,
                  cmd.read, cmd.update, cmd.decay1, cmd.decay2}))
        else $error("More than one datapath command in one cycle.");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decay2 |=> out_valid_reg)
        else $error("A finished result was not presented.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("A stalled result was dropped.");

    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && step_reg == '0) |=> (state_reg == ST_ADDR1))
        else $error("The grid search did not end on its last bit.");
`endif

endmodule

FILE: sv/tpmd_datapath.sv
// Datapath: quantizers, policy table, action and drive state, decay and output register.
module tpmd_datapath #(
    parameter int ANGLE_POINTS = 20,
    parameter int RATE_POINTS  = 50,
    parameter int WHEEL_POINTS = 100
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tpmd_pkg::tpmd_cmd_t                   cmd,
    input  logic [tpmd_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                  cfg_we,
    input  logic [tpmd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tpmd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [tpmd_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int AW    = $clog2(ANGLE_POINTS);
    localparam int RW    = $clog2(RATE_POINTS);
    localparam int WW    = $clog2(WHEEL_POINTS);
    localparam int DEPTH = ANGLE_POINTS * RATE_POINTS * WHEEL_POINTS;
    localparam int ADW   = $clog2(DEPTH);
    localparam int CW    = (ADW > tpmd_pkg::ADDR_W) ? ADW : tpmd_pkg::ADDR_W;
    localparam int GAW   = (AW > tpmd_pkg::GATE_ANGLE_W) ? AW : tpmd_pkg::GATE_ANGLE_W;
    localparam int GRW   = (RW > tpmd_pkg::GATE_RATE_W) ? RW : tpmd_pkg::GATE_RATE_W;
    localparam int DW    = tpmd_pkg::DRIVE_W;

    logic signed [tpmd_pkg::SAMPLE_W-1:0] angle_in;
    logic signed [tpmd_pkg::SAMPLE_W-1:0] rate_in;
    logic signed [tpmd_pkg::SAMPLE_W-1:0] wheel_in;
    logic [tpmd_pkg::ADDR_W-1:0]          entry_address;
    logic [tpmd_pkg::ACTION_W-1:0]        entry_action;
    logic [AW-1:0]                        angle_idx;
    logic [RW-1:0]                        rate_idx;
    logic [WW-1:0]                        wheel_idx;

    logic [tpmd_pkg::GATE_ANGLE_W-1:0]    gate_angle_reg;
    logic [tpmd_pkg::GATE_RATE_W-1:0]     gate_rate_reg;
    logic                                 gate_hit_reg;
    logic [ADW-1:0]                       addr1_reg;
    logic [ADW-1:0]                       addr_reg;
    logic [tpmd_pkg::ACTION_W-1:0]        store_reg [DEPTH];
    logic [tpmd_pkg::ACTION_W-1:0]        rd_reg;
    logic                                 store_we;

    logic signed [tpmd_pkg::ACTION_W-1:0] action_dec;
    logic signed [tpmd_pkg::ACTION_W-1:0] current_action_reg;
    logic signed [tpmd_pkg::ACTION_W-1:0] current_action_next;
    logic signed [tpmd_pkg::ACTION_W-1:0] previous_action_reg;
    logic signed [tpmd_pkg::ACTION_W-1:0] previous_action_next;
    logic signed [DW-1:0]                 drive_level_reg;
    logic signed [DW-1:0]                 drive_level_next;
    logic signed [DW-1:0]                 kick;

    logic signed [14:0]                   drive_x4;
    logic signed [14:0]                   decay_sum;
    logic [tpmd_pkg::DECAY_W-1:0]         decay_reg;
    logic                                 rev_reg;
    logic [2*tpmd_pkg::DECAY_W-1:0]       quot_prod;
    logic [tpmd_pkg::MAG_W-1:0]           quot;

    logic signed [tpmd_pkg::ACTION_W-1:0] out_action_reg;
    logic                                 out_rev_reg;
    logic [tpmd_pkg::MAG_W-1:0]           out_mag_reg;

    assign entry_address = s_tdata[tpmd_pkg::ADDR_LSB +: tpmd_pkg::ADDR_W];
    assign entry_action  = s_tdata[tpmd_pkg::ACTION_LSB +: tpmd_pkg::ACTION_W];
    assign angle_in      = $signed(s_tdata[tpmd_pkg::ANGLE_LSB +: tpmd_pkg::SAMPLE_W]);
    assign rate_in       = $signed(s_tdata[tpmd_pkg::RATE_LSB +: tpmd_pkg::SAMPLE_W]);
    assign wheel_in      = $signed(s_tdata[tpmd_pkg::WHEEL_LSB +: tpmd_pkg::SAMPLE_W]);

    tpmd_snap #(
        .POINTS (ANGLE_POINTS),
        .HALF   (tpmd_pkg::ANGLE_HALF_SPAN)
    ) u_snap_angle (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .step_bit (cmd.step_bit),
        .sample   (angle_in),
        .index    (angle_idx)
    );

    tpmd_snap #(
        .POINTS (RATE_POINTS),
        .HALF   (tpmd_pkg::RATE_HALF_SPAN)
    ) u_snap_rate (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .step_bit (cmd.step_bit),
        .sample   (rate_in),
        .index    (rate_idx)
    );

    tpmd_snap #(
        .POINTS (WHEEL_POINTS),
        .HALF   (tpmd_pkg::WHEEL_HALF_SPAN)
    ) u_snap_wheel (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .step_bit (cmd.step_bit),
        .sample   (wheel_in),
        .index    (wheel_idx)
    );

    assign store_we = cmd.write && (CW'(entry_address) < CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[ADW'(entry_address)] <= entry_action;
        end
        if (cmd.read)
        begin
            rd_reg <= store_reg[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr1)
        begin
            addr1_reg    <= ADW'(rate_idx) + ADW'(RATE_POINTS) * ADW'(angle_idx);
            gate_hit_reg <= (GAW'(angle_idx) == GAW'(gate_angle_reg))
                         || (GRW'(rate_idx) == GRW'(gate_rate_reg));
        end
        if (cmd.addr2)
        begin
            addr_reg <= ADW'(wheel_idx) + ADW'(WHEEL_POINTS) * addr1_reg;
        end
        if (cmd.decay1)
        begin
            decay_reg <= decay_sum[tpmd_pkg::DECAY_W-1:0];
            rev_reg   <= (drive_level_reg <= 0);
        end
        if (cmd.decay2)
        begin
            out_action_reg <= current_action_reg;
            out_rev_reg    <= rev_reg;
            out_mag_reg    <= quot;
        end
    end

    always_comb
    begin
        action_dec = $signed(rd_reg);
        if (action_dec == tpmd_pkg::ACT_INVALID)
        begin
            action_dec = tpmd_pkg::ACT_ZERO;
        end
        case (action_dec)
            tpmd_pkg::ACT_POS: kick = -tpmd_pkg::DRIVE_KICK;
            tpmd_pkg::ACT_NEG: kick = tpmd_pkg::DRIVE_KICK;
            default:           kick = '0;
        endcase

        drive_x4 = 15'(drive_level_reg) <<< 2;
        if (drive_level_reg > 0)
        begin
            decay_sum = drive_x4 + tpmd_pkg::DECAY_OFFSET;
        end
        else
        begin
            decay_sum = tpmd_pkg::DECAY_OFFSET - drive_x4;
        end
        quot_prod = (2*tpmd_pkg::DECAY_W)'(decay_reg) * (2*tpmd_pkg::DECAY_W)'(tpmd_pkg::RECIP_FIVE);
        quot      = quot_prod[tpmd_pkg::RECIP_SHIFT +: tpmd_pkg::MAG_W];

        current_action_next  = current_action_reg;
        previous_action_next = previous_action_reg;
        drive_level_next     = drive_level_reg;
        if (cmd.update && !gate_hit_reg)
        begin
            current_action_next = action_dec;
            if (action_dec != previous_action_reg)
            begin
                previous_action_next = action_dec;
                drive_level_next     = kick;
            end
        end
        else if (cmd.decay2)
        begin
            if (rev_reg)
            begin
                drive_level_next = -DW'(quot);
            end
            else
            begin
                drive_level_next = DW'(quot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_action_reg  <= tpmd_pkg::ACT_ZERO;
            previous_action_reg <= tpmd_pkg::ACT_ZERO;
            drive_level_reg     <= '0;
            gate_angle_reg      <= '0;
            gate_rate_reg       <= '0;
        end
        else
        begin
            current_action_reg  <= current_action_next;
            previous_action_reg <= previous_action_next;
            drive_level_reg     <= drive_level_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tpmd_pkg::REG_GATE_ANGLE:
                        gate_angle_reg <= cfg_data[tpmd_pkg::GATE_ANGLE_W-1:0];
                    tpmd_pkg::REG_GATE_RATE:
                        gate_rate_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign m_tdata = {2'b00, out_mag_reg, out_rev_reg, out_action_reg};

`ifndef NO_ASSERTIONS
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_level_reg >= -tpmd_pkg::DRIVE_KICK) && (drive_level_reg <= tpmd_pkg::DRIVE_KICK))
        else $error("Drive level left its range.");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decay2 |=> (out_mag_reg <= tpmd_pkg::MAG_MAX))
        else $error("Drive magnitude above its limit.");

    a_gate_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && gate_hit_reg) |=>
            ($stable(current_action_reg) && $stable(previous_action_reg)))
        else $error("Action changed on a gated tick.");
`endif

endmodule
